[rtl/ptrx_pkg.sv]
package ptrx_pkg;

  localparam int unsigned VALUE_W = 31;
  localparam int unsigned VER_W   = 10;
  localparam int unsigned NODE_W  = 15;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned NODES   = 32768;
  localparam int unsigned KIND_W  = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATE = 2'd0,
    KIND_COPY   = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_REDUCE,
    S_DISPATCH,
    S_C_ROOT_RD,
    S_C_ROOT_WR,
    S_C_RD,
    S_C_WR,
    S_C_LEAF_RD,
    S_C_LEAF_WR,
    S_COPY_RD,
    S_COPY_WR,
    S_Q_RD_HI,
    S_Q_RD_LO,
    S_Q_LOAD_B,
    S_Q_CH,
    S_Q_CNT,
    S_Q_STEP,
    S_RESP_OK,
    S_RESP_ERR
  } state_e;

  typedef enum logic [1:0] {
    RSEL_TGT,
    RSEL_BASE,
    RSEL_BM1
  } root_sel_e;

  // child pair of one node, index 0 and index 1
  typedef logic [1:0][NODE_W-1:0] children_t;

  typedef struct packed {
    logic      latch_in;
    logic      clr_step;
    logic      red_step;
    logic      root_rd;
    root_sel_e root_sel;
    logic      root_wr_new;
    logic      copy_wr;
    logic      node_rd_prev;
    logic      node_wr_level;
    logic      node_wr_leaf;
    logic      q_init_a;
    logic      q_init_b;
    logic      q_rd_ch;
    logic      q_rd_cnt;
    logic      q_step;
    logic      resp_load;
    logic      resp_err;
  } dp_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  base_zero;
    logic  pool_full;
    logic  clr_last;
    logic  level_zero;
    logic  out_free;
  } dp_status_t;

endpackage

[rtl/ptrx_ctrl.sv]
module ptrx_ctrl
  import ptrx_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  dp_status_t status_i,
  output logic       in_stall_o,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_REDUCE;
      end
      S_REDUCE: state_d = S_DISPATCH;
      S_DISPATCH: begin
        case (status_i.kind)
          KIND_CREATE: state_d = status_i.pool_full ? S_RESP_ERR : S_C_ROOT_RD;
          KIND_COPY:   state_d = S_COPY_RD;
          KIND_QUERY:  state_d = status_i.base_zero ? S_RESP_ERR : S_Q_RD_HI;
          default:     state_d = S_IDLE;
        endcase
      end
      S_C_ROOT_RD: state_d = S_C_ROOT_WR;
      S_C_ROOT_WR: state_d = S_C_RD;
      S_C_RD:      state_d = S_C_WR;
      S_C_WR: begin
        state_d = status_i.level_zero ? S_C_LEAF_RD : S_C_RD;
      end
      S_C_LEAF_RD: state_d = S_C_LEAF_WR;
      S_C_LEAF_WR: state_d = S_IDLE;
      S_COPY_RD:   state_d = S_COPY_WR;
      S_COPY_WR:   state_d = S_IDLE;
      S_Q_RD_HI:   state_d = S_Q_RD_LO;
      S_Q_RD_LO:   state_d = S_Q_LOAD_B;
      S_Q_LOAD_B:  state_d = S_Q_CH;
      S_Q_CH:      state_d = S_Q_CNT;
      S_Q_CNT:     state_d = S_Q_STEP;
      S_Q_STEP: begin
        state_d = status_i.level_zero ? S_RESP_OK : S_Q_CH;
      end
      S_RESP_OK, S_RESP_ERR: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_CLEAR:    cmd_o.clr_step = 1'b1;
      S_IDLE:     cmd_o.latch_in = in_valid_i;
      S_REDUCE:   cmd_o.red_step = 1'b1;
      S_DISPATCH: ;
      S_C_ROOT_RD: begin
        cmd_o.root_rd  = 1'b1;
        cmd_o.root_sel = RSEL_BASE;
      end
      S_C_ROOT_WR: cmd_o.root_wr_new   = 1'b1;
      S_C_RD:      cmd_o.node_rd_prev  = 1'b1;
      S_C_WR:      cmd_o.node_wr_level = 1'b1;
      S_C_LEAF_RD: cmd_o.node_rd_prev  = 1'b1;
      S_C_LEAF_WR: cmd_o.node_wr_leaf  = 1'b1;
      S_COPY_RD: begin
        cmd_o.root_rd  = 1'b1;
        cmd_o.root_sel = RSEL_BASE;
      end
      S_COPY_WR: cmd_o.copy_wr = 1'b1;
      S_Q_RD_HI: begin
        cmd_o.root_rd  = 1'b1;
        cmd_o.root_sel = RSEL_TGT;
      end
      S_Q_RD_LO: begin
        cmd_o.root_rd  = 1'b1;
        cmd_o.root_sel = RSEL_BM1;
        cmd_o.q_init_a = 1'b1;
      end
      S_Q_LOAD_B: cmd_o.q_init_b = 1'b1;
      S_Q_CH:     cmd_o.q_rd_ch  = 1'b1;
      S_Q_CNT:    cmd_o.q_rd_cnt = 1'b1;
      S_Q_STEP:   cmd_o.q_step   = 1'b1;
      S_RESP_OK:  cmd_o.resp_load = status_i.out_free;
      S_RESP_ERR: begin
        cmd_o.resp_load = status_i.out_free;
        cmd_o.resp_err  = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

[rtl/ptrx_datapath.sv]
module ptrx_datapath
  import ptrx_pkg::*;
#(
  parameter int unsigned VERSIONS = 1024,
  parameter int unsigned TOP_BIT  = 30
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_status_t         status_o,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [VER_W-1:0]   target_version_i,
  input  logic [VER_W-1:0]   base_version_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [VALUE_W-1:0] max_xor_o,
  output logic               error_o
);

  localparam int unsigned VW = $clog2(VERSIONS);
  localparam int unsigned LW = $clog2(TOP_BIT + 1);
  localparam int unsigned RED_SH = 2 * VER_W;
  localparam int unsigned RW = VER_W + RED_SH + 1;
  localparam logic [RW-1:0] VER_MOD   = RW'(VERSIONS);
  localparam logic [RW-1:0] VER_RECIP = RW'((1 << RED_SH) / VERSIONS);
  localparam logic [NODE_W-1:0] USED_LIMIT = NODE_W'(NODES - 1 - (TOP_BIT + 2));
  localparam int unsigned NW = $clog2(NODES);

  // remainder modulo the version count: reciprocal multiply, then at most one subtract
  function automatic logic [VER_W-1:0] red_f(logic [VER_W-1:0] v);
    logic [RW-1:0]    prod;
    logic [VER_W-1:0] q;
    logic [RW-1:0]    r;
    prod = RW'(v) * VER_RECIP;
    q    = VER_W'(prod >> RED_SH);
    r    = RW'(v) - RW'(q) * VER_MOD;
    if (r >= VER_MOD) begin
      r = r - VER_MOD;
    end
    return VER_W'(r);
  endfunction

  // request fields
  logic [KIND_W-1:0]  kind_q;
  logic [VER_W-1:0]   tgt_q, base_q, bm1_q;
  logic               base_zero_q;
  logic [VALUE_W-1:0] x_q;

  // control state
  logic [VW-1:0]      clr_cnt_q;
  logic [NODE_W-1:0]  used_q, used_d;
  logic               out_valid_q;

  // walk registers
  logic [NODE_W-1:0]  prev_q, cur_q, a_q, b_q;
  logic [LW-1:0]      level_q;
  logic [VALUE_W-1:0] acc_q;
  logic [VALUE_W-1:0] max_xor_q;
  logic               error_q;

  // version root memory
  logic [NODE_W-1:0]  root_mem [VERSIONS];
  logic [NODE_W-1:0]  root_rdata_q;
  logic [VW-1:0]      root_raddr, root_waddr;
  logic [NODE_W-1:0]  root_wdata;
  logic               root_we;

  // node memories
  children_t          ch_mem [NODES];
  logic [COUNT_W-1:0] cnt_mem [NODES];
  children_t          ch_a_q, ch_b_q, ch_a, ch_b, ch_wdata;
  logic               ch_a_zero_q, ch_b_zero_q;
  logic [COUNT_W-1:0] cnt_a_q, cnt_b_q, cnt_a, cnt_b;
  logic               cnt_a_zero_q, cnt_b_zero_q;
  logic [NODE_W-1:0]  ch_raddr_a, cnt_raddr_a, cnt_raddr_b;
  logic               ch_re_a, cnt_re_a;

  logic [VALUE_W-1:0] lvl_sel;
  logic               xbit, flip, tsel;

  assign lvl_sel = VALUE_W'(1) << level_q;
  assign xbit    = |(x_q & lvl_sel);

  // node zero is the empty node and is never written
  assign ch_a  = ch_a_zero_q  ? '0 : ch_a_q;
  assign ch_b  = ch_b_zero_q  ? '0 : ch_b_q;
  assign cnt_a = cnt_a_zero_q ? '0 : cnt_a_q;
  assign cnt_b = cnt_b_zero_q ? '0 : cnt_b_q;

  assign flip = (cnt_a > cnt_b);
  assign tsel = xbit ^ flip;

  // root memory ports
  always_comb begin
    case (cmd_i.root_sel)
      RSEL_TGT:  root_raddr = VW'(tgt_q);
      RSEL_BASE: root_raddr = VW'(base_q);
      RSEL_BM1:  root_raddr = VW'(bm1_q);
      default:   root_raddr = VW'(tgt_q);
    endcase
  end

  assign root_we    = cmd_i.clr_step | cmd_i.root_wr_new | cmd_i.copy_wr;
  assign root_waddr = cmd_i.clr_step ? clr_cnt_q : VW'(tgt_q);
  assign root_wdata = cmd_i.clr_step    ? '0 :
                      cmd_i.root_wr_new ? NODE_W'(used_q + 1'b1) : root_rdata_q;

  always_ff @(posedge clk_i) begin
    if (root_we) begin
      root_mem[root_waddr] <= root_wdata;
    end
    if (cmd_i.root_rd) begin
      root_rdata_q <= root_mem[root_raddr];
    end
  end

  // node memory ports
  assign ch_re_a     = cmd_i.node_rd_prev | cmd_i.q_rd_ch;
  assign ch_raddr_a  = cmd_i.q_rd_ch ? a_q : prev_q;
  assign cnt_re_a    = cmd_i.node_rd_prev | cmd_i.q_rd_cnt;
  assign cnt_raddr_a = cmd_i.q_rd_cnt ? ch_a[~xbit] : prev_q;
  assign cnt_raddr_b = ch_b[~xbit];

  always_comb begin
    ch_wdata        = ch_a;
    ch_wdata[xbit]  = NODE_W'(cur_q + 1'b1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.node_wr_level) begin
      ch_mem[NW'(cur_q)] <= ch_wdata;
    end
    if (cmd_i.node_wr_level || cmd_i.node_wr_leaf) begin
      cnt_mem[NW'(cur_q)] <= COUNT_W'(cnt_a + 1'b1);
    end
    if (ch_re_a) begin
      ch_a_q      <= ch_mem[NW'(ch_raddr_a)];
      ch_a_zero_q <= (ch_raddr_a == '0);
    end
    if (cmd_i.q_rd_ch) begin
      ch_b_q      <= ch_mem[NW'(b_q)];
      ch_b_zero_q <= (b_q == '0);
    end
    if (cnt_re_a) begin
      cnt_a_q      <= cnt_mem[NW'(cnt_raddr_a)];
      cnt_a_zero_q <= (cnt_raddr_a == '0);
    end
    if (cmd_i.q_rd_cnt) begin
      cnt_b_q      <= cnt_mem[NW'(cnt_raddr_b)];
      cnt_b_zero_q <= (cnt_raddr_b == '0);
    end
  end

  always_comb begin
    used_d = used_q;
    if (cmd_i.root_wr_new || cmd_i.node_wr_level) begin
      used_d = NODE_W'(used_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_cnt_q <= VW'(clr_cnt_q + 1'b1);
      end
      used_q <= used_d;
      if (cmd_i.resp_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      kind_q      <= kind_i;
      tgt_q       <= target_version_i;
      base_q      <= base_version_i;
      bm1_q       <= VER_W'(base_version_i - 1'b1);
      base_zero_q <= (base_version_i == '0);
      x_q         <= value_i;
    end
    if (cmd_i.red_step) begin
      tgt_q  <= red_f(tgt_q);
      base_q <= red_f(base_q);
      bm1_q  <= red_f(bm1_q);
    end
    if (cmd_i.root_wr_new) begin
      prev_q  <= root_rdata_q;
      cur_q   <= NODE_W'(used_q + 1'b1);
      level_q <= LW'(TOP_BIT);
    end
    if (cmd_i.node_wr_level) begin
      prev_q  <= ch_a[xbit];
      cur_q   <= NODE_W'(cur_q + 1'b1);
      level_q <= LW'(level_q - 1'b1);
    end
    if (cmd_i.q_init_a) begin
      a_q     <= root_rdata_q;
      acc_q   <= x_q;
      level_q <= LW'(TOP_BIT);
    end
    if (cmd_i.q_init_b) begin
      b_q <= root_rdata_q;
    end
    if (cmd_i.q_step) begin
      a_q     <= ch_a[tsel];
      b_q     <= ch_b[tsel];
      acc_q   <= flip ? (acc_q | lvl_sel) : (acc_q & ~lvl_sel);
      level_q <= LW'(level_q - 1'b1);
    end
    if (cmd_i.resp_load) begin
      max_xor_q <= cmd_i.resp_err ? '0 : acc_q;
      error_q   <= cmd_i.resp_err;
    end
  end

  assign status_o.kind       = kind_e'(kind_q);
  assign status_o.base_zero  = base_zero_q;
  assign status_o.pool_full  = (used_q > USED_LIMIT);
  assign status_o.clr_last   = (clr_cnt_q == VW'(VERSIONS - 1));
  assign status_o.level_zero = (level_q == '0);
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign max_xor_o   = max_xor_q;
  assign error_o     = error_q;

endmodule

[rtl/persistent_trie_range_max_xor.sv]
// Persistent binary trie over 31-bit values with range max-xor queries. After reset the
// block clears its version root table, one entry a cycle, and takes no request until
// then. Requests are handled one at a time: each request passes through accept, a step
// that reduces the version numbers and dispatch. A copy then reads one root entry and
// writes it back under the target version. Create and query walk the trie level by
// level, since every trie level waits on a registered node memory read before the next
// node address is known: on create each level reads the previous node, then writes its
// copy; on query each level reads the children of both versions, then their counts, then
// steps. A failed create or a query with base version zero answers with error set and
// max_xor zero. The result sits in an output register, so a new request is taken while
// an earlier result is still stalled.
module persistent_trie_range_max_xor
  import ptrx_pkg::*;
#(
  parameter int unsigned VERSIONS = 1024,
  parameter int unsigned TOP_BIT  = 30
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [VER_W-1:0]   target_version_i,
  input  logic [VER_W-1:0]   base_version_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [VALUE_W-1:0] max_xor_o,
  output logic               error_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  ptrx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  ptrx_datapath #(
    .VERSIONS (VERSIONS),
    .TOP_BIT  (TOP_BIT)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .kind_i           (kind_i),
    .target_version_i (target_version_i),
    .base_version_i   (base_version_i),
    .value_i          (value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .max_xor_o        (max_xor_o),
    .error_o          (error_o)
  );

endmodule

[tb/sv/persistent_trie_range_max_xor_tb.sv]
module persistent_trie_range_max_xor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptrx_pkg::*;

  localparam int unsigned VER_COUNT    = 1024;
  localparam int          TRIE_TOP     = 30;
  localparam int unsigned CHAIN0       = 64;
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 256;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // shadow copy of the trie: predicts every answer and checks it on arrival
  class trie_shadow;
    typedef struct packed {
      logic [VALUE_W-1:0] max_xor;
      logic               error;
    } answer_t;

    logic [NODE_W-1:0]  root_of [VER_COUNT];
    children_t          kids    [NODES];
    logic [COUNT_W-1:0] tally   [NODES];
    int unsigned        used;
    answer_t            answers_due [$];
    int unsigned        mismatches, matched;
    int unsigned        n_create, n_copy, n_query, n_error, n_ignored;
    bit                 pool_full;

    function new();
      foreach (root_of[i]) root_of[i] = '0;
      foreach (kids[i]) begin
        kids[i]  = '0;
        tally[i] = '0;
      end
      used       = 0;
      mismatches = 0;
      matched    = 0;
      n_create   = 0;
      n_copy     = 0;
      n_query    = 0;
      n_error    = 0;
      n_ignored  = 0;
      pool_full  = 1'b0;
    endfunction

    // path copy of one insert; base root is read before the target root is written
    function bit insert_path(logic [VER_W-1:0] tgt, logic [VER_W-1:0] base,
                             logic [VALUE_W-1:0] x);
      logic [NODE_W-1:0] prev, cur, nxt;
      logic b;
      prev = root_of[base];
      if (used + TRIE_TOP + 2 > NODES - 1) return 1'b0;
      used++;
      cur = NODE_W'(used);
      root_of[tgt] = cur;
      for (int i = TRIE_TOP; i >= 0; i--) begin
        b = x[i];
        tally[cur] = tally[prev] + 1'b1;
        used++;
        nxt = NODE_W'(used);
        kids[cur][!b] = kids[prev][!b];
        kids[cur][b]  = nxt;
        kids[nxt]     = '0;
        cur  = nxt;
        prev = kids[prev][b];
      end
      tally[cur] = tally[prev] + 1'b1;
      return 1'b1;
    endfunction

    // both counts are non-negative, so a positive difference is a plain greater-than
    function logic [VALUE_W-1:0] walk_max_xor(logic [NODE_W-1:0] hi_root,
                                              logic [NODE_W-1:0] lo_root,
                                              logic [VALUE_W-1:0] x);
      logic [NODE_W-1:0]  hi, lo;
      logic [VALUE_W-1:0] path;
      logic t;
      hi   = hi_root;
      lo   = lo_root;
      path = '0;
      for (int i = TRIE_TOP; i >= 0; i--) begin
        t = x[i];
        if (tally[kids[hi][!t]] > tally[kids[lo][!t]]) t = !t;
        path[i] = t;
        hi = kids[hi][t];
        lo = kids[lo][t];
      end
      return path ^ x;
    endfunction

    function void note_request(logic [KIND_W-1:0] k, logic [VER_W-1:0] tgt,
                               logic [VER_W-1:0] base, logic [VALUE_W-1:0] x);
      answer_t ans;
      ans.max_xor = '0;
      ans.error   = 1'b1;
      case (k)
        KIND_CREATE: begin
          n_create++;
          if (!insert_path(tgt, base, x)) begin
            pool_full = 1'b1;
            n_error++;
            answers_due.push_back(ans);
          end
        end
        KIND_COPY: begin
          n_copy++;
          root_of[tgt] = root_of[base];
        end
        KIND_QUERY: begin
          n_query++;
          if (base == '0) begin
            n_error++;
          end else begin
            ans.max_xor = walk_max_xor(root_of[tgt], root_of[base - 1'b1], x);
            ans.error   = 1'b0;
          end
          answers_due.push_back(ans);
        end
        default: n_ignored++;
      endcase
    endfunction

    function void check_result(logic [VALUE_W-1:0] got_xor, logic got_err);
      answer_t want;
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: max_xor=%h error=%b", got_xor, got_err);
        return;
      end
      want = answers_due.pop_front();
      if (got_xor !== want.max_xor || got_err !== want.error) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected max_xor=%h error=%b, got max_xor=%h error=%b",
                   want.max_xor, want.error, got_xor, got_err);
      end else begin
        matched++;
      end
    endfunction

    function int unsigned pending();
      return answers_due.size();
    endfunction
  endclass

  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               in_valid_i       = 1'b0;
  logic               in_stall_o;
  logic [KIND_W-1:0]  kind_i           = '0;
  logic [VER_W-1:0]   target_version_i = '0;
  logic [VER_W-1:0]   base_version_i   = '0;
  logic [VALUE_W-1:0] value_i          = '0;
  logic               out_valid_o;
  logic               out_stall_i      = 1'b0;
  logic [VALUE_W-1:0] max_xor_o;
  logic               error_o;

  trie_shadow         shadow;
  int unsigned        tx_count   = 0;
  int unsigned        rx_taken   = 0;
  int unsigned        rx_wait    = 0;
  int unsigned        hold_left  = 0;
  int unsigned        cycle_cnt  = 0;
  logic [VALUE_W-1:0] recent [$];

  persistent_trie_range_max_xor #(
    .VERSIONS(VER_COUNT),
    .TOP_BIT (TRIE_TOP)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .target_version_i(target_version_i),
    .base_version_i  (base_version_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .max_xor_o       (max_xor_o),
    .error_o         (error_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAIL");
      $finish;
    end
  end

  // every third stretch of 40 requests runs with no idling at all
  function automatic int unsigned idle_cycles(int unsigned n);
    if ((n / 40) % 3 == 2) return 0;
    return $urandom_range(0, 4);
  endfunction

  function automatic logic [VER_W-1:0] chain_ver(int unsigned k);
    return VER_W'(CHAIN0 + k);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = '0;
      1:       v = '1;
      2:       v = VALUE_W'($urandom_range(0, 15));
      3, 4: begin
        // near an inserted value so the walk agrees deep into the trie
        if (recent.size() != 0)
          v = recent[$urandom_range(0, recent.size() - 1)]
              ^ (VALUE_W'(1) << $urandom_range(0, TRIE_TOP));
        else
          v = VALUE_W'($urandom());
      end
      default: v = VALUE_W'($urandom());
    endcase
    return v;
  endfunction

  // receiver: random stall per result, plus one long hold-off to back the block up
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        shadow.check_result(max_xor_o, error_o);
        rx_taken++;
        rx_wait = idle_cycles(rx_taken);
        if (rx_taken == 40) hold_left = 600;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (rx_wait != 0) begin
        rx_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_request(logic [KIND_W-1:0] k, logic [VER_W-1:0] tgt,
                              logic [VER_W-1:0] base, logic [VALUE_W-1:0] x);
    int unsigned gap;
    gap = idle_cycles(tx_count);
    tx_count++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    kind_i           <= k;
    target_version_i <= tgt;
    base_version_i   <= base;
    value_i          <= x;
    in_valid_i       <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    shadow.note_request(k, tgt, base, x);
  endtask

  initial begin : stimulus
    int unsigned        chain_len;
    int unsigned        served;
    int unsigned        pick;
    int unsigned        hi_k, lo_k;
    logic [KIND_W-1:0]  k;
    logic [VALUE_W-1:0] v;
    bit                 failed;

    shadow = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty trie, extremes, own-base create, copies, unordered range
    send_request(KIND_QUERY,  10'd0,    10'd0,    31'h0000_0000);
    send_request(KIND_QUERY,  10'd1023, 10'd1,    31'h7FFF_FFFF);
    send_request(KIND_CREATE, 10'd1,    10'd0,    31'h0000_0000);
    send_request(KIND_CREATE, 10'd2,    10'd1,    31'h7FFF_FFFF);
    send_request(KIND_CREATE, 10'd3,    10'd2,    31'h5555_5555);
    send_request(KIND_CREATE, 10'd3,    10'd3,    31'h2AAA_AAAA);
    send_request(KIND_COPY,   10'd1023, 10'd3,    31'h7FFF_FFFF);
    send_request(KIND_COPY,   10'd10,   10'd2,    31'h0000_0000);
    send_request(KIND_QUERY,  10'd3,    10'd1,    31'h0000_0000);
    send_request(KIND_QUERY,  10'd3,    10'd1,    31'h7FFF_FFFF);
    send_request(KIND_QUERY,  10'd3,    10'd1,    31'h5555_5555);
    send_request(KIND_QUERY,  10'd1023, 10'd2,    31'h0000_0000);
    send_request(KIND_QUERY,  10'd1,    10'd3,    31'h0001_2345);
    send_request(KIND_QUERY,  10'd10,   10'd1023, 31'h0000_0000);
    send_request(KIND_UNUSED, 10'd3,    10'd3,    31'h7FFF_FFFF);
    send_request(KIND_CREATE, 10'd1023, 10'd1023, 31'h7FFF_FFFF);
    send_request(KIND_QUERY,  10'd1023, 10'd1023, 31'h0000_0000);
    send_request(KIND_QUERY,  10'd0,    10'd1,    31'h0000_1234);
    send_request(KIND_QUERY,  10'd1023, 10'd4,    31'h2AAA_AAAA);

    // sender pause: let every outstanding answer drain
    in_valid_i <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk_i);

    // random: mostly a chain of prefix versions with range queries over it
    chain_len = 0;
    served    = 0;
    while (served < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45 || chain_len == 0) begin
        v = pick_value();
        send_request(KIND_CREATE, chain_ver(chain_len + 1), chain_ver(chain_len), v);
        recent.push_back(v);
        if (recent.size() > 64) void'(recent.pop_front());
        chain_len++;
      end else if (pick < 80) begin
        hi_k = $urandom_range(1, chain_len);
        lo_k = $urandom_range(1, hi_k);
        send_request(KIND_QUERY, chain_ver(hi_k), chain_ver(lo_k), pick_value());
      end else if (pick < 86) begin
        send_request(KIND_COPY, VER_W'($urandom_range(1000, 1023)),
                     chain_ver($urandom_range(0, chain_len)), pick_value());
      end else if (pick < 90) begin
        send_request(KIND_QUERY, VER_W'($urandom_range(1000, 1023)),
                     chain_ver($urandom_range(1, chain_len)), pick_value());
      end else if (pick < 95) begin
        // range not nested
        send_request(KIND_QUERY, chain_ver($urandom_range(0, chain_len)),
                     chain_ver($urandom_range(0, chain_len)), pick_value());
      end else begin
        k = KIND_W'($urandom_range(0, 3));
        send_request(k, VER_W'($urandom()), VER_W'($urandom()), VALUE_W'($urandom()));
        if (k == KIND_UNUSED) continue;
      end
      served++;
    end

    // keep extending the chain until the node pool runs dry
    while (!shadow.pool_full) begin
      v = VALUE_W'($urandom());
      send_request(KIND_CREATE, chain_ver(chain_len + 1), chain_ver(chain_len), v);
      chain_len++;
    end
    repeat (3)
      send_request(KIND_CREATE, VER_W'($urandom()), VER_W'($urandom()), pick_value());
    repeat (6) begin
      hi_k = chain_len - $urandom_range(0, 200);
      lo_k = hi_k - $urandom_range(0, 300);
      send_request(KIND_QUERY, chain_ver(hi_k), chain_ver(lo_k), VALUE_W'($urandom()));
    end

    in_valid_i <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d creates, %0d copies, %0d queries, %0d ignored, %0d error answers",
             shadow.n_create, shadow.n_copy, shadow.n_query, shadow.n_ignored,
             shadow.n_error);
    $display("pool exhausted: %0d, results matched: %0d, mismatches: %0d, outstanding: %0d",
             shadow.pool_full, shadow.matched, shadow.mismatches, shadow.pending());
    failed = (shadow.mismatches != 0) || (shadow.pending() != 0);
    if (!failed) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
